>>> hdl/pab_pkg.sv
// shared types and constants for the packet ack bitfield block
// no dependencies; imported by pab_core and packet_ack_bitfield
package pab_pkg;

	// sequence number and window geometry
	localparam int SN_BITS      = 16;
	localparam int WINDOW_BYTES = 4;
	localparam int WIN_BITS     = WINDOW_BYTES * 8;
	localparam int DIST_BITS    = $clog2(WIN_BITS + 1);
	localparam int IDX_BITS     = $clog2(WIN_BITS);

	// item operation codes
	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	typedef logic [SN_BITS-1:0]  sn_t;
	typedef logic [WIN_BITS-1:0] win_t;

	typedef struct packed {
		logic mode;
		sn_t  seq_num;
		sn_t  prev_seq_num;
	} pab_req_t;

	typedef struct packed {
		sn_t  latest_sn;
		win_t ack_bits;
		logic acked;
	} pab_rsp_t;

	// wrap-aware distance from older b up to newer a, zero if a is not newer
	function automatic sn_t sn_distance(sn_t a, sn_t b);
		sn_t d;
		d = a - b;
		if (d != '0 && !d[SN_BITS-1]) begin
			return d;
		end
		return '0;
	endfunction

endpackage

>>> hdl/pab_core.sv
// ack window state and the combinational record / query logic
// depends on pab_pkg
module pab_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  pab_pkg::pab_req_t item,
	output pab_pkg::pab_rsp_t result
);
	import pab_pkg::*;

	sn_t  latest_q;
	win_t win_q;
	logic first_q;

	sn_t                 sn_gap;
	logic                in_win;
	logic [DIST_BITS-1:0] sh;
	logic [IDX_BITS-1:0]  idx;
	sn_t                 latest_nxt;
	win_t                win_nxt;
	logic                first_nxt;
	logic                acked;

	// distance: record measures seq from prev, query measures latest from asked
	always_comb begin
		if (item.mode == MODE_RECORD) begin
			sn_gap = sn_distance(item.seq_num, item.prev_seq_num);
		end else begin
			sn_gap = sn_distance(latest_q, item.seq_num);
		end
		in_win = (sn_gap != '0) && (sn_gap <= sn_t'(WIN_BITS));
		sh     = sn_gap[DIST_BITS-1:0];
		idx    = IDX_BITS'(sh - DIST_BITS'(1));
	end

	// next state and query answer
	always_comb begin
		latest_nxt = latest_q;
		win_nxt    = win_q;
		first_nxt  = first_q;
		acked      = 1'b0;
		unique case (item.mode)
			MODE_RECORD: begin
				latest_nxt = item.seq_num;
				first_nxt  = 1'b0;
				if (!first_q) begin
					if (sn_gap > sn_t'(WIN_BITS)) begin
						win_nxt = '0;
					end else if (in_win) begin
						win_nxt = (win_q << sh) | (win_t'(1) << idx);
					end
				end
			end
			MODE_QUERY: begin
				if (in_win) begin
					acked = win_q[idx];
				end
			end
			default: ;
		endcase
	end

	// state registers advance when the item is taken into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latest_q <= '0;
			win_q    <= '0;
			first_q  <= 1'b1;
		end else if (fire) begin
			latest_q <= latest_nxt;
			win_q    <= win_nxt;
			first_q  <= first_nxt;
		end
	end

	assign result.latest_sn = latest_nxt;
	assign result.ack_bits  = win_nxt;
	assign result.acked     = acked;

	// a record always becomes the latest number and ends the first-record case
	a_record_latest: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_RECORD |=> latest_q == $past(item.seq_num) && !first_q)
		else $error("record did not update latest number");

	// a query leaves the state alone
	a_query_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_QUERY |=> latest_q == $past(latest_q) && win_q == $past(win_q))
		else $error("query changed window state");

	// a record inside the window marks the previous number
	a_record_marks: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_RECORD && !first_q && in_win |=> win_q[$past(idx)])
		else $error("ack bit not set by record");

endmodule

>>> hdl/packet_ack_bitfield.sv
// top level of the packet ack bitfield block: input and result registers
// depends on pab_pkg and pab_core
//
// Usage:
//   req channel  (req_valid / req_stall / req): one item per header, mode
//     record stores seq_num as latest and marks prev_seq_num in the bitmap,
//     mode query asks whether seq_num is marked.
//   rsp channel  (rsp_valid / rsp_stall / rsp): exactly one item per request,
//     carrying the latest number, the 32-bit ack bitmap and the query answer.
//   Path: a request is held in the input register, its result in the result
//     register that drives rsp. Throughput: one item per cycle while
//     rsp_stall is low; the distance subtract, window shift and bit set
//     are combinational between the input register and result register.
//   Reset clears latest number and bitmap and arms the first-record case,
//     in which a record only stores the latest number.
//   When rsp_stall holds, the result register keeps its item, the input
//     register can still take one more item, and req_stall rises only
//     once both are full.
module packet_ack_bitfield (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  pab_pkg::pab_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output pab_pkg::pab_rsp_t rsp
);
	import pab_pkg::*;

	pab_req_t req_s1;
	logic     v_s1;
	pab_rsp_t rsp_s2;
	logic     v_s2;
	logic     adv2;
	pab_rsp_t core_rsp;

	// result stage takes a new item when empty or being drained
	assign adv2      = !v_s2 || !rsp_stall;
	assign req_stall = v_s1 && !adv2;

	pab_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (v_s1 && adv2),
		.item   (req_s1),
		.result (core_rsp)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!req_stall) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			rsp_s2 <= core_rsp;
		end
	end

	assign rsp_valid = v_s2;
	assign rsp       = rsp_s2;

	// backpressure only when both registers hold an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> v_s1 && v_s2 && rsp_stall)
		else $error("input stalled while a register was free");

	// an item leaving the input register lands in the result register
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv2 |=> v_s2)
		else $error("item lost between stages");

	// a stalled result item stays valid and unchanged
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result item changed");

endmodule
